// ----- rtl/pil_pkg.sv -----
package pil_pkg;

  // Operation carried in the low bits of each input item
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned DataW = 32;

  // Broadcast to every cell; the position travels alongside
  typedef struct packed {
    logic ins;  // write at position, cells above take left neighbour
    logic era;  // cells at or above position take right neighbour
  } cmd_t;

endpackage

// ----- rtl/pil_cell.sv -----
module pil_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                     clk_i,
  input  pil_pkg::cmd_t            cmd_i,
  input  logic [CntW-1:0]          pos_i,
  input  logic [pil_pkg::DataW-1:0] val_i,
  input  logic [pil_pkg::DataW-1:0] left_i,
  input  logic [pil_pkg::DataW-1:0] right_i,
  output logic [pil_pkg::DataW-1:0] data_o
);
  import pil_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [DataW-1:0] data_d, data_q;
  logic             at_pos, above;

  assign at_pos = (pos_i == MyIdx);
  assign above  = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        data_d = val_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (cmd_i.era) begin
      if (at_pos || above) begin
        data_d = right_i;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/positional_insert_erase_list.sv -----
// Positional insert/erase list: an ordered list of signed 32-bit entries held
// in a row of cells, one cell per entry, CAPACITY cells in all.
// Input channel (s_axis): one item per operation - append, insert at a
// position, erase at a position, or read at a position.
// Output channel (m_axis): exactly one item per input item, carrying the read
// value (zero unless a read succeeds), the entry count after the operation
// and a status (ok, position out of range, list full).
// The result is registered and appears in the cycle after the input item is accepted.
// Throughput: one item per cycle while the output is not stalled. Insert and
// erase shift the entries from the position onward by one place, each cell
// loading from a neighbour; a read selects one cell through the read mux.
// Stall: the output register holds its item while m_axis_tready_i is low,
// and s_axis_tready_o then drops until the item is taken, so nothing is lost.
// Reset: the count clears to zero and the output register empties; cell
// contents are left as they are, since no entry is read before it is
// written.
module positional_insert_erase_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // mode[1:0], position[CntW+1:2], value[CntW+33:CntW+2], zero pad
  input  logic [((2 + $clog2(CAPACITY + 1) + 32 + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // read_value[31:0], count[CntW+31:32], status[CntW+33:CntW+32], zero pad
  output logic [((2 + $clog2(CAPACITY + 1) + 32 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);
  import pil_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned BusW = ((2 + CntW + DataW + 7) / 8) * 8;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // input unpacking
  mode_e              mode;
  logic [CntW-1:0]    pos;
  logic [DataW-1:0]   val;
  logic               accept;

  assign mode   = mode_e'(s_axis_tdata_i[1:0]);
  assign pos    = s_axis_tdata_i[2 +: CntW];
  assign val    = s_axis_tdata_i[2 + CntW +: DataW];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  logic [CntW-1:0]  count_d, count_q;
  logic             full;
  logic [DataW-1:0] ent [CAPACITY];

  assign full = (count_q == CapCnt);

  // operation decode
  cmd_t             cmd;
  logic [CntW-1:0]  cmd_pos;
  status_e          st;
  logic [DataW-1:0] rd;

  always_comb begin
    cmd     = '0;
    cmd_pos = pos;
    st      = ST_OK;
    rd      = '0;
    count_d = count_q;
    unique case (mode)
      MODE_APPEND: begin
        // append is an insert at the current count
        cmd_pos = count_q;
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      MODE_INSERT: begin
        // range check before full check
        if (pos > count_q) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      MODE_ERASE: begin
        if (pos >= count_q) begin
          st = ST_RANGE;
        end else begin
          cmd.era = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      MODE_READ: begin
        if (pos >= count_q) begin
          st = ST_RANGE;
        end else begin
          rd = ent[pos[IdxW-1:0]];
        end
      end
    endcase
  end

  cmd_t cell_cmd;
  assign cell_cmd = accept ? cmd : '0;

  // row of cells; each loads from a neighbour on insert and erase
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = ent[g+1];
    end
    pil_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .pos_i   (cmd_pos),
      .val_i   (val),
      .left_i  (left),
      .right_i (right),
      .data_o  (ent[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // output register
  logic            out_valid_q;
  logic [BusW-1:0] out_data_d, out_data_q;

  always_comb begin
    out_data_d                     = '0;
    out_data_d[DataW-1:0]          = rd;
    out_data_d[DataW +: CntW]      = count_d;
    out_data_d[DataW + CntW +: 2]  = st;
  end

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // checks
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted item produced no result");

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (m_axis_tdata_o[DataW +: CntW] == count_q))
    else $error("reported count differs from held count");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[DataW + CntW +: 2] != ST_OK))
      |-> (m_axis_tdata_o[DataW-1:0] == '0))
    else $error("failed operation returned a non-zero value");

endmodule

// ----- dv/tb_positional_insert_erase_list.sv -----
module tb_positional_insert_erase_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pil_pkg::*;

  // Block geometry, matching the port widths of the list
  localparam int unsigned Capacity   = 16;
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned TdW        = ((2 + CntW + 32 + 7) / 8) * 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RxHoldLen  = 300;
  localparam int unsigned TailCycles = 8;

  // One pending operation on the input side
  typedef struct {
    mode_e             mode;
    logic [CntW-1:0]   pos;
    logic signed [31:0] val;
  } list_op_t;

  // One result item as the list should report it
  typedef struct {
    logic signed [31:0] read_value;
    logic [CntW-1:0]    count;
    status_e            status;
  } list_res_t;

  logic           clk_i           = 1'b0;
  logic           rst_ni          = 1'b0;
  logic           s_axis_tvalid_i = 1'b0;
  logic           s_axis_tready_o;
  // mode[1:0], position[6:2], value[38:7], zero pad
  logic [TdW-1:0] s_axis_tdata_i  = '0;
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i = 1'b0;
  // read_value[31:0], count[36:32], status[38:37], zero pad
  logic [TdW-1:0] m_axis_tdata_o;

  positional_insert_erase_list #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Operations waiting to be offered, and results still owed by the block
  list_op_t  pending_ops[$];
  list_res_t owed_results[$];

  // Shadow copy of the list, updated once per accepted item
  logic signed [31:0] shadow_entries [Capacity];
  int unsigned        shadow_count = 0;

  // Entry count as the stimulus generator sees it (values do not matter)
  int unsigned gen_count = 0;

  int unsigned cycle_cnt   = 0;
  int unsigned error_cnt   = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          in_taken    = 1'b0;

  // Long receiver hold-off: requested by toggling, counted down by the ready process
  bit          rx_hold_req  = 1'b0;
  bit          rx_hold_seen = 1'b0;
  int unsigned rx_hold_left = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow list and work out the result item
  function automatic list_res_t apply_list_op(input list_op_t op);
    list_res_t   res;
    int unsigned p;
    int unsigned i;
    res.read_value = '0;
    res.status     = ST_OK;
    p              = op.pos;
    case (op.mode)
      MODE_APPEND: begin
        if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = op.val;
          shadow_count++;
        end
      end
      MODE_INSERT: begin
        // range check wins over the full check
        if (p > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = op.val;
          shadow_count++;
        end
      end
      MODE_ERASE: begin
        if (p >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (p >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_entries[p];
      end
    endcase
    res.count = shadow_count[CntW-1:0];
    return res;
  endfunction

  function automatic logic [TdW-1:0] pack_op(input list_op_t op);
    logic [TdW-1:0] word;
    word            = '0;
    word[1:0]       = op.mode;
    word[CntW+1:2]  = op.pos;
    word[CntW+33:CntW+2] = op.val;
    return word;
  endfunction

  // Queue an operation and track the count it leaves behind
  task automatic queue_op(input mode_e m, input int unsigned p, input logic signed [31:0] v);
    list_op_t op;
    op.mode = m;
    op.pos  = p[CntW-1:0];
    op.val  = v;
    pending_ops.push_back(op);
    case (m)
      MODE_APPEND: if (gen_count < Capacity) gen_count++;
      MODE_INSERT: if (p <= gen_count && gen_count < Capacity) gen_count++;
      MODE_ERASE:  if (p < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // trend 0 grows the list, 1 shrinks it, 2 mixes; most positions land in range
  task automatic queue_random_op(input int unsigned trend);
    mode_e       m;
    int unsigned w;
    int unsigned p;
    w = $urandom_range(0, 99);
    case (trend)
      0:       m = (w < 40) ? MODE_APPEND : (w < 75) ? MODE_INSERT :
                   (w < 85) ? MODE_ERASE  : MODE_READ;
      1:       m = (w < 10) ? MODE_APPEND : (w < 20) ? MODE_INSERT :
                   (w < 70) ? MODE_ERASE  : MODE_READ;
      default: m = mode_e'(w[1:0]);
    endcase
    if ($urandom_range(0, 99) < 15 || m == MODE_APPEND) begin
      p = $urandom_range(0, Capacity);
    end else if (m == MODE_INSERT) begin
      p = $urandom_range(0, gen_count);
    end else begin
      p = (gen_count == 0) ? $urandom_range(0, Capacity) : $urandom_range(0, gen_count - 1);
    end
    queue_op(m, p, rand_value());
  endtask

  task automatic queue_random_run(input int unsigned n_items);
    int unsigned left;
    int unsigned burst;
    int unsigned trend;
    left = n_items;
    while (left > 0) begin
      // short bursts of one trend so that the list swings between empty and full
      burst = $urandom_range(8, 40);
      if (burst > left) burst = left;
      trend = (gen_count < 4) ? 0 : (gen_count > 12) ? $urandom_range(1, 2) :
              $urandom_range(0, 2);
      repeat (burst) queue_random_op(trend);
      left -= burst;
    end
  endtask

  // Sender holds off until every queued item went in and every result came out
  task automatic wait_drained();
    while (pending_ops.size() != 0 || owed_results.size() != 0 || s_axis_tvalid_i)
      @(posedge clk_i);
  endtask

  // Driver: a new item only once the present one has been taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pack_op(pending_ops.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver ready, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RxHoldLen;
    end
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: check the result first, then predict from the input taken at this edge
  always @(posedge clk_i) begin
    list_res_t want;
    list_res_t got;
    list_op_t  op;
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.read_value = m_axis_tdata_o[31:0];
      got.count      = m_axis_tdata_o[CntW+31:32];
      got.status     = status_e'(m_axis_tdata_o[CntW+33:CntW+32]);
      if (owed_results.size() == 0) begin
        $display("%0t: result with none owed: value %0d count %0d status %0d", $time,
                 got.read_value, got.count, got.status);
        error_cnt++;
      end else begin
        want = owed_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                   got.read_value);
          error_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          error_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_cnt++;
        end
      end
    end
    if (in_taken) begin
      op.mode = mode_e'(s_axis_tdata_i[1:0]);
      op.pos  = s_axis_tdata_i[CntW+1:2];
      op.val  = s_axis_tdata_i[CntW+33:CntW+2];
      owed_results.push_back(apply_list_op(op));
    end
  end

  initial begin
    int unsigned k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-list errors, extremes, insert at the end, full-list cases
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_op(MODE_READ,   0, 0);             // read on empty list
    queue_op(MODE_ERASE,  0, 0);             // erase on empty list
    queue_op(MODE_INSERT, 1, 5);             // insert past the end
    queue_op(MODE_INSERT, 0, 32'sh8000_0000);
    queue_op(MODE_APPEND, 16, 32'sh7fff_ffff);
    queue_op(MODE_INSERT, 2, -32'sd1);       // insert at count acts as append
    queue_op(MODE_INSERT, 1, 32'sh0);
    queue_op(MODE_READ,   0, 0);
    queue_op(MODE_READ,   3, 0);
    queue_op(MODE_READ,   4, 0);             // read at count
    queue_op(MODE_ERASE,  1, 0);
    queue_op(MODE_ERASE,  3, 0);             // erase at count
    queue_op(MODE_READ,   1, 0);
    for (k = gen_count; k < Capacity; k++) queue_op(MODE_APPEND, 0, $urandom);
    queue_op(MODE_APPEND, 0, 32'sh1234_5678); // append on full list
    queue_op(MODE_INSERT, 16, 7);             // insert at count on full list
    queue_op(MODE_INSERT, 3, 7);              // insert in range on full list
    queue_op(MODE_READ,   15, 0);
    queue_op(MODE_READ,   16, 0);
    queue_op(MODE_ERASE,  15, 0);
    queue_op(MODE_ERASE,  0, 0);
    queue_op(MODE_READ,   0, 0);
    wait_drained();

    // Random, busy sender and sparse receiver
    tx_idle_pct = 9;
    rx_idle_pct = 62;
    queue_random_run(450);
    wait_drained();

    // Random, the other way round
    tx_idle_pct = 62;
    rx_idle_pct = 9;
    queue_random_run(450);
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_run(200);
    rx_hold_req = ~rx_hold_req;
    wait_drained();

    // Flat out, no idling on either side
    queue_random_run(300);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (error_cnt == 0 && owed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- positional_insert_erase_list.f -----
rtl/pil_pkg.sv
rtl/pil_cell.sv
rtl/positional_insert_erase_list.sv
dv/tb_positional_insert_erase_list.sv
